>>> src/qwrp_pkg.sv
// qwrp_pkg: shared widths, register indexes and reset values for the work range partitioner
// no dependencies

package qwrp_pkg;

	// field widths
	localparam int SIZE_W  = 32;
	localparam int PARTS_W = 7;
	localparam int QUANT_W = 16;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_MAX_PARTS = 2'd0;
	localparam logic [IDX_W-1:0] REG_PREF      = 2'd1;
	localparam logic [IDX_W-1:0] REG_QUANTUM   = 2'd2;

	// configuration reset values
	localparam logic [PARTS_W-1:0] RST_MAX_PARTS = 7'd8;
	localparam logic [SIZE_W-1:0]  RST_PREF      = 32'd1024;
	localparam logic [QUANT_W-1:0] RST_QUANTUM   = 16'd16;

endpackage

>>> src/qwrp_div.sv
// qwrp_div: restoring divider, one quotient bit per cycle
// depends on qwrp_pkg

module qwrp_div
	import qwrp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SIZE_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [SIZE_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SIZE_W + 1);

	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] quo_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SIZE_W:0]   shifted;
	logic [SIZE_W:0]   diff;

	// trial subtraction of the divisor from the shifted partial remainder
	assign shifted = {rem_q, quo_q[SIZE_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SIZE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[SIZE_W]) begin
				rem_q <= diff[SIZE_W-1:0];
				quo_q <= {quo_q[SIZE_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SIZE_W-1:0];
				quo_q <= {quo_q[SIZE_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> src/quantized_work_range_partitioner_unit.sv
// quantized_work_range_partitioner_unit: splits a total size into quantum aligned chunks
// depends on qwrp_pkg and qwrp_div
//
// a total below twice the preferred chunk size goes straight to the emit state as its single chunk;
// otherwise the first chunk waits for three divisions on the shared divider, interleaved with
// three products on the shared multiplier, then one chunk per cycle while the output flows
// one request at a time: the next request is taken once the last chunk is registered
// asynchronous active-low reset clears the sequencer and output valid and loads the config reset values

module quantized_work_range_partitioner_unit
	import qwrp_pkg::*;
#(
	parameter int MAX_CHUNKS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// config write port
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// request stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [SIZE_W-1:0]  s_tdata,   // [31:0] total_size
	// chunk stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [2*SIZE_W-1:0] m_tdata,  // [31:0] chunk_start, [63:32] chunk_length
	output logic               m_tlast    // final_chunk
);

	// sequencer codes
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_W1   = 4'd1;
	localparam logic [3:0] ST_M1   = 4'd2;
	localparam logic [3:0] ST_G2   = 4'd3;
	localparam logic [3:0] ST_W2   = 4'd4;
	localparam logic [3:0] ST_M2   = 4'd5;
	localparam logic [3:0] ST_M3   = 4'd6;
	localparam logic [3:0] ST_M4   = 4'd7;
	localparam logic [3:0] ST_G3   = 4'd8;
	localparam logic [3:0] ST_W3   = 4'd9;
	localparam logic [3:0] ST_EMIT = 4'd10;

	localparam logic [PARTS_W-1:0] CAP_MAX = PARTS_W'(MAX_CHUNKS);

	logic [3:0]         state_q;
	logic [PARTS_W-1:0] max_parts_q;
	logic [SIZE_W-1:0]  pref_q;
	logic [QUANT_W-1:0] quantum_q;

	logic [SIZE_W-1:0]  total_q;
	logic [QUANT_W-1:0] qe_q;
	logic [PARTS_W-1:0] cap_q;
	logic [PARTS_W-1:0] count_q;
	logic [SIZE_W-1:0]  part_q;
	logic [PARTS_W-1:0] extra_q;
	logic [PARTS_W-1:0] idx_q;
	logic [SIZE_W-1:0]  start_q;
	logic [SIZE_W-1:0]  mul_q;

	logic [SIZE_W-1:0]  m_start_q;
	logic [SIZE_W-1:0]  m_len_q;
	logic               m_last_q;
	logic               m_tvalid_q;

	logic [QUANT_W-1:0] qe;
	logic [SIZE_W-1:0]  pe;
	logic [PARTS_W-1:0] cap;
	logic               accept;
	logic               one_chunk;

	logic               div_start;
	logic [SIZE_W-1:0]  div_dividend;
	logic [SIZE_W-1:0]  div_divisor;
	logic               div_done;
	logic [SIZE_W-1:0]  div_quo;

	logic [SIZE_W-1:0]  mul_a;
	logic [QUANT_W-1:0] mul_b;
	logic [SIZE_W+QUANT_W-1:0] mul_p;

	logic               out_free;
	logic               is_last;
	logic [SIZE_W-1:0]  len;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_parts_q <= RST_MAX_PARTS;
			pref_q      <= RST_PREF;
			quantum_q   <= RST_QUANTUM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_PARTS: max_parts_q <= cfg_data[PARTS_W-1:0];
				REG_PREF:      pref_q      <= cfg_data[SIZE_W-1:0];
				REG_QUANTUM:   quantum_q   <= cfg_data[QUANT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective quantum, preferred size and chunk cap
	always_comb begin
		qe  = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
		pe  = (pref_q < SIZE_W'(qe)) ? SIZE_W'(qe) : pref_q;
		if (max_parts_q == '0)
			cap = PARTS_W'(1);
		else if (max_parts_q > CAP_MAX)
			cap = CAP_MAX;
		else
			cap = max_parts_q;
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign one_chunk = (s_tdata >> 1) < pe;

	// divider operand select
	always_comb begin
		div_start    = 1'b0;
		div_dividend = s_tdata;
		div_divisor  = pe;
		unique case (state_q)
			ST_IDLE: div_start = accept && !one_chunk;
			ST_G2: begin
				div_start    = 1'b1;
				div_dividend = total_q;
				div_divisor  = mul_q;
			end
			ST_G3: begin
				div_start    = 1'b1;
				div_dividend = total_q - mul_q;
				div_divisor  = SIZE_W'(qe_q);
			end
			default: ;
		endcase
	end

	qwrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// shared multiplier operand select, product registered
	always_comb begin
		mul_a = SIZE_W'(count_q);
		mul_b = qe_q;
		unique case (state_q)
			ST_M2: mul_a = div_quo;
			ST_M4: begin
				mul_a = part_q;
				mul_b = QUANT_W'(count_q);
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_p[SIZE_W-1:0];
	end

	// next chunk length
	assign out_free = !m_tvalid_q || m_tready;
	assign is_last  = (idx_q == count_q - 1'b1);
	always_comb begin
		if (is_last)
			len = total_q - start_q;
		else if (idx_q < extra_q)
			len = part_q + SIZE_W'(qe_q);
		else
			len = part_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			count_q    <= '0;
			idx_q      <= '0;
		end else begin
			if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (one_chunk) begin
							count_q <= PARTS_W'(1);
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_W1;
						end
					end
				end
				ST_W1: begin
					if (div_done) begin
						count_q <= (div_quo > SIZE_W'(cap_q)) ? cap_q : div_quo[PARTS_W-1:0];
						state_q <= ST_M1;
					end
				end
				ST_M1: state_q <= ST_G2;
				ST_G2: state_q <= ST_W2;
				ST_W2: begin
					if (div_done)
						state_q <= ST_M2;
				end
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_G3;
				ST_G3: state_q <= ST_W3;
				ST_W3: begin
					if (div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						idx_q      <= idx_q + 1'b1;
						if (is_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			total_q <= s_tdata;
			qe_q    <= qe;
			cap_q   <= cap;
			start_q <= '0;
			extra_q <= '0;
			part_q  <= '0;
		end
		if (state_q == ST_M3)
			part_q <= mul_q;
		if (state_q == ST_W3 && div_done)
			extra_q <= div_quo[PARTS_W-1:0];
		if (state_q == ST_EMIT && out_free) begin
			m_start_q <= start_q;
			m_len_q   <= len;
			m_last_q  <= is_last;
			start_q   <= start_q + len;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_len_q, m_start_q};
	assign m_tlast  = m_last_q;

endmodule
